>>> design/wod_pkg.sv
// Package for the weighted offset deformer.
// Holds field widths, mode codes and the item and queue entry types.
// No dependencies.
package wod_pkg;

    localparam int POS_BITS    = 32;
    localparam int IDX_BITS    = 16;
    localparam int W_BITS      = 16;
    localparam int CNT_BITS    = 11;
    localparam int DIFF_BITS   = POS_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_LOAD_STATIC = 2'd0;
    localparam logic [1:0] MODE_LOAD_ANIM   = 2'd1;
    localparam logic [1:0] MODE_INFLUENCE   = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [IDX_BITS-1:0] entry_index;
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [POS_BITS-1:0] pos_z;
        logic [W_BITS-1:0]          weight;
        logic                       last_influence;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_BITS-1:0] out_x;
        logic signed [POS_BITS-1:0] out_y;
        logic signed [POS_BITS-1:0] out_z;
        logic                       moved;
    } t_out_item;

    // One influence request handed from the front to the back.
    typedef struct packed {
        logic [2:0][DIFF_BITS-1:0] diff;
        logic [2:0][POS_BITS-1:0]  pos;
        logic [W_BITS-1:0]         weight;
        logic                      counted;
        logic                      last;
    } t_q_entry;

endpackage

>>> design/wod_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wod_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/wod_fifo.sv
// Short request queue between the front and the back of the deformer.
// Depends on wod_pkg.
module wod_fifo
    import wod_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_q_entry             i_push_data,
    input  logic                 i_pop,
    output t_q_entry             o_head,
    output logic                 o_empty,
    output logic [QCNT_BITS-1:0] o_count
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_q_entry             r_mem [QUEUE_DEPTH];
    logic [PW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]        r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_BITS'(i_push) - QCNT_BITS'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < QCNT_BITS'(QUEUE_DEPTH))
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("request queue read while empty");

endmodule

>>> design/wod_front.sv
// Front of the deformer: accepts items, keeps the deformer count, writes the
// position tables and turns influence items into queue requests.
// Depends on wod_pkg and wod_ram.
module wod_front
    import wod_pkg::*;
#(
    parameter int DEFORMER_POINTS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CNT_BITS-1:0]  i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    input  logic [QCNT_BITS-1:0] i_q_count,
    output logic                 o_push,
    output t_q_entry             o_push_data
);
    localparam int AW = (DEFORMER_POINTS > 1) ? $clog2(DEFORMER_POINTS) : 1;
    localparam int RW = 3 * POS_BITS;
    localparam logic [IDX_BITS:0] NPTS = (IDX_BITS + 1)'(DEFORMER_POINTS);

    logic [CNT_BITS-1:0] r_count;
    logic                accept;
    logic                idx_ok;
    logic [IDX_BITS:0]   idx_ext;
    logic                in_table;
    logic                in_count;
    logic                is_infl;
    logic                counted;
    logic [AW-1:0]       addr;
    logic [RW-1:0]       wdata;
    logic [RW-1:0]       stat_q;
    logic [RW-1:0]       anim_q;

    logic                r_s1_valid, n_s1_valid;
    logic                r_s1_counted;
    logic                r_s1_last;
    logic [W_BITS-1:0]   r_s1_weight;
    logic [2:0][POS_BITS-1:0] r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_comb begin
        o_in_ready = ({1'b0, i_q_count} + (QCNT_BITS + 1)'(r_s1_valid))
                     < (QCNT_BITS + 1)'(QUEUE_DEPTH);
        accept   = i_in_valid && o_in_ready;
        idx_ok   = !i_in_data.entry_index[IDX_BITS-1];
        idx_ext  = {2'b00, i_in_data.entry_index[IDX_BITS-2:0]};
        in_table = idx_ok && (idx_ext < NPTS);
        in_count = idx_ok && (idx_ext < (IDX_BITS + 1)'(r_count));
        is_infl  = (i_in_data.mode == MODE_INFLUENCE);
        counted  = is_infl && (i_in_data.weight != '0) && in_table && in_count;
        addr     = AW'(i_in_data.entry_index[IDX_BITS-2:0]);
        wdata    = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
        // Skipped influences only need a request when they close a point.
        n_s1_valid = accept && is_infl && (counted || i_in_data.last_influence);
    end

    wod_ram #(.WIDTH(RW), .DEPTH(DEFORMER_POINTS)) u_static_tab (
        .i_clk   (i_clk),
        .i_we    (accept && (i_in_data.mode == MODE_LOAD_STATIC) && in_table),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (accept && counted),
        .i_raddr (addr),
        .o_rdata (stat_q)
    );

    wod_ram #(.WIDTH(RW), .DEPTH(DEFORMER_POINTS)) u_anim_tab (
        .i_clk   (i_clk),
        .i_we    (accept && (i_in_data.mode == MODE_LOAD_ANIM) && in_table),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (accept && counted),
        .i_raddr (addr),
        .o_rdata (anim_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_counted <= counted;
            r_s1_last    <= i_in_data.last_influence;
            r_s1_weight  <= i_in_data.weight;
            r_s1_pos     <= {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
        end
    end

    // Table data arrives in the cycle after the read; skipped requests carry a
    // zero difference and weight so that they leave the sums alone.
    always_comb begin
        o_push_data.pos     = r_s1_pos;
        o_push_data.counted = r_s1_counted;
        o_push_data.last    = r_s1_last;
        o_push_data.weight  = r_s1_counted ? r_s1_weight : '0;
        for (int k = 0; k < 3; k++) begin
            o_push_data.diff[k] = r_s1_counted
                ? DIFF_BITS'($signed({anim_q[k*POS_BITS + POS_BITS-1],
                                      anim_q[k*POS_BITS +: POS_BITS]})
                           - $signed({stat_q[k*POS_BITS + POS_BITS-1],
                                      stat_q[k*POS_BITS +: POS_BITS]}))
                : '0;
        end
    end

    assign o_push = r_s1_valid;

    a_load_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_data.mode == MODE_LOAD_STATIC
                   || i_in_data.mode == MODE_LOAD_ANIM) |=> !r_s1_valid)
        else $error("load item produced a queue request");

endmodule

>>> design/wod_back.sv
// Back of the deformer: weights the offsets, accumulates them per point and
// rounds, adds and saturates the result for the output register.
// Depends on wod_pkg.
module wod_back
    import wod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_entry   i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data
);
    localparam int PROD_BITS = DIFF_BITS + W_BITS + 1;
    localparam int ACC_BITS  = 64;
    localparam int RND_BITS  = ACC_BITS - 15;
    localparam int SUM_BITS  = RND_BITS + 1;
    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< 14;
    localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic [ACC_BITS:0] s;
        s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
        if (s[ACC_BITS] != s[ACC_BITS-1]) begin
            return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                               : {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return s[ACC_BITS-1:0];
    endfunction

    logic en;

    logic                         r_a_valid;
    logic                         r_a_counted;
    logic                         r_a_last;
    logic [2:0][PROD_BITS-1:0]    r_a_prod;
    logic [2:0][POS_BITS-1:0]     r_a_pos;

    logic [2:0][ACC_BITS-1:0]     r_sum, n_sum;
    logic                         r_any, n_any;

    logic                         r_b_valid;
    logic [2:0][ACC_BITS-1:0]     r_b_fin;
    logic                         r_b_any;
    logic [2:0][POS_BITS-1:0]     r_b_pos;

    logic                         r_r_valid;
    logic [2:0][RND_BITS-1:0]     r_r_rnd;
    logic                         r_r_any;
    logic [2:0][POS_BITS-1:0]     r_r_pos;

    logic                         r_o_valid;
    t_out_item                    r_o_data;

    logic [2:0][ACC_BITS-1:0]     acc_next;
    logic [2:0][ACC_BITS-1:0]     rnd_full;
    logic [2:0][SUM_BITS-1:0]     pos_sum;
    logic [2:0][POS_BITS-1:0]     sat_out;

    // The whole back pipeline moves together; it halts only while a result
    // sits in the output register unread.
    assign en    = !r_o_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_next[k] = sat_add(r_sum[k],
                                  ACC_BITS'($signed(r_a_prod[k])));
            rnd_full[k] = sat_add(r_b_fin[k], HALF);
            pos_sum[k]  = SUM_BITS'($signed(r_r_pos[k]))
                        + SUM_BITS'($signed(r_r_rnd[k]));
            if ($signed(pos_sum[k]) > SUM_BITS'(POS_MAX)) begin
                sat_out[k] = POS_MAX;
            end else if ($signed(pos_sum[k]) < $signed(SUM_BITS'(POS_MIN))) begin
                sat_out[k] = POS_MIN;
            end else begin
                sat_out[k] = pos_sum[k][POS_BITS-1:0];
            end
        end
        n_sum = r_sum;
        n_any = r_any;
        if (r_a_valid) begin
            if (r_a_last) begin
                n_sum = '0;
                n_any = 1'b0;
            end else begin
                n_sum = acc_next;
                n_any = r_any || r_a_counted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_sum     <= '0;
            r_any     <= 1'b0;
        end else if (en) begin
            r_a_valid <= !i_empty;
            r_b_valid <= r_a_valid && r_a_last;
            r_r_valid <= r_b_valid;
            r_o_valid <= r_r_valid;
            r_sum     <= n_sum;
            r_any     <= n_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_counted <= i_head.counted;
            r_a_last    <= i_head.last;
            r_a_pos     <= i_head.pos;
            for (int k = 0; k < 3; k++) begin
                r_a_prod[k] <= PROD_BITS'($signed(i_head.diff[k])
                                          * $signed({1'b0, i_head.weight}));
            end
            r_b_fin <= acc_next;
            r_b_any <= r_any || r_a_counted;
            r_b_pos <= r_a_pos;
            for (int k = 0; k < 3; k++) begin
                r_r_rnd[k] <= rnd_full[k][ACC_BITS-1:15];
            end
            r_r_any <= r_b_any;
            r_r_pos <= r_b_pos;
            r_o_data.out_x <= sat_out[0];
            r_o_data.out_y <= sat_out[1];
            r_o_data.out_z <= sat_out[2];
            r_o_data.moved <= r_r_any;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_a_valid && r_a_last |=> (r_sum == '0) && !r_any)
        else $error("accumulator not cleared after a closing influence");

    a_moved_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_a_valid && r_a_counted && !r_a_last |=> r_any)
        else $error("counted influence did not mark the point as moved");

endmodule

>>> design/weighted_offset_deform.sv
// Throughput: one item per cycle while o_in_ready is high; each counted
// influence does one read of each table and one multiply-accumulate, and the
// back stalls only on an unread output register.
// Reset clears the deformer count, the sums and all valid flags; the position
// tables hold nothing defined until loaded.
module weighted_offset_deform
    import wod_pkg::*;
#(
    parameter int DEFORMER_POINTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);
    logic                 push;
    t_q_entry             push_data;
    logic                 pop;
    t_q_entry             head;
    logic                 empty;
    logic [QCNT_BITS-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    wod_front #(.DEFORMER_POINTS(DEFORMER_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_push_data (push_data)
    );

    wod_fifo u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (empty),
        .o_count     (q_count)
    );

    wod_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
